>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define FCL_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// condition must never be seen at a clock edge out of reset
`define FCL_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

>>> hdl/fcl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcl_pkg
// Types, constants and helpers for the dense layer forward block.
// ----------------------------------------------------------------------------
package fcl_pkg;

	// default sizes
	localparam int MAX_INPUTS_DEF  = 16;
	localparam int MAX_OUTPUTS_DEF = 16;
	localparam int DATA_WIDTH_DEF  = 16;

	// fixed field widths
	localparam int OP_W      = 2;
	localparam int IDX_W     = 4;
	localparam int CNT_W     = 5;
	localparam int REG_IDX_W = 1;

	// arithmetic
	localparam int ACC_W  = 40;
	localparam int FRAC_W = 8;

	// count registers after reset
	localparam logic [CNT_W-1:0] CNT_RESET = 5'd16;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_INPUT_COUNT  = 1'd0;
	localparam logic [REG_IDX_W-1:0] REG_OUTPUT_COUNT = 1'd1;

	// item operations
	typedef enum logic [OP_W-1:0] {
		OP_WEIGHT = 2'd0,
		OP_BIAS   = 2'd1,
		OP_ELEM   = 2'd2
	} op_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_OUT
	} state_t;

	// address width of a store of the given depth, never below one bit
	function automatic int addr_width(input int depth);
		int w;
		w = $clog2(depth);
		return (w < 1) ? 1 : w;
	endfunction

	// a count of zero acts as one, a count above the maximum as the maximum
	function automatic int clamp_count(input logic [CNT_W-1:0] c, input int maxv);
		int v;
		v = int'(c);
		if (v == 0)
			return 1;
		else if (v > maxv)
			return maxv;
		else
			return v;
	endfunction

endpackage

>>> hdl/fcl_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcl_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module fcl_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hdl/fully_connected_layer_forward_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fully_connected_layer_forward_top
// Dense layer forward pass out = W*x + b in signed Q8.8 with 40-bit
// accumulators. Weights, biases and accumulators sit in three RAMs; one
// multiply-accumulate unit walks the rows in use for each input element.
//
//   channel  | handshake                   | payload
//   ---------+-----------------------------+----------------------------------
//   item     | item_valid / item_ready     | op, row_index, col_index, value,
//            |                             | vector_end
//   result   | result_valid / result_ready | out_row, out_value, out_last
//   config   | cfg_we (no wait)            | cfg_index, cfg_data
//
// Loads, reserved ops and elements outside the columns in use keep the block
// ready unless an element ends a vector. An element in a column in use walks
// the rows in use, one read per row through the accumulator RAM port, then
// waits while the multiply and write-back stages drain before the next item.
// On vector end each row goes through the accumulator and bias read ports
// with one row in flight; the pass stalls on the output register while
// result_ready is low; the next item is taken while the last result waits.
// Reset clears one valid bit per accumulator row; no clearing pass is run.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fully_connected_layer_forward_top #(
	parameter int MAX_INPUTS  = fcl_pkg::MAX_INPUTS_DEF,
	parameter int MAX_OUTPUTS = fcl_pkg::MAX_OUTPUTS_DEF,
	parameter int DATA_WIDTH  = fcl_pkg::DATA_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration
	input  logic                              cfg_we,
	input  logic [fcl_pkg::REG_IDX_W-1:0]     cfg_index,
	input  logic [fcl_pkg::CNT_W-1:0]         cfg_data,
	// item channel
	input  logic                              item_valid,
	output logic                              item_ready,
	input  logic [fcl_pkg::OP_W-1:0]          op,
	input  logic [fcl_pkg::IDX_W-1:0]         row_index,
	input  logic [fcl_pkg::IDX_W-1:0]         col_index,
	input  logic signed [DATA_WIDTH-1:0]      value,
	input  logic                              vector_end,
	// result channel
	output logic                              result_valid,
	input  logic                              result_ready,
	output logic [fcl_pkg::IDX_W-1:0]         out_row,
	output logic signed [DATA_WIDTH-1:0]      out_value,
	output logic                              out_last
);

	import fcl_pkg::*;

	localparam int ROW_W   = addr_width(MAX_OUTPUTS);
	localparam int WADDR_W = addr_width(MAX_OUTPUTS * MAX_INPUTS);
	localparam int PROD_W  = 2 * DATA_WIDTH;
	localparam int MSUM_W  = ((PROD_W > ACC_W) ? PROD_W : ACC_W) + 1;
	localparam int SUM_W   = (((DATA_WIDTH + FRAC_W) > ACC_W) ?
		(DATA_WIDTH + FRAC_W) : ACC_W) + 2;
	localparam int Q_W     = SUM_W - FRAC_W;

	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
	localparam logic signed [DATA_WIDTH-1:0] DATA_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam logic signed [DATA_WIDTH-1:0] DATA_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
	localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) <<< (FRAC_W - 1);

	// configuration registers
	logic [CNT_W-1:0] input_count_q;
	logic [CNT_W-1:0] output_count_q;

	// sequencer
	state_t               state_q, state_d;
	logic [ROW_W-1:0]     row_q;
	logic [WADDR_W-1:0]   waddr_q;
	logic signed [DATA_WIDTH-1:0] val_q;
	logic                 last_q;
	logic [MAX_OUTPUTS-1:0] acc_valid_q;

	// MAC pipeline
	logic                 mac_s1_v, mac_s2_v;
	logic [ROW_W-1:0]     mac_row_s1, mac_row_s2;
	logic                 mac_vld_s1;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_s2;

	// output pipeline
	logic                 out_s1_v;
	logic [ROW_W-1:0]     out_row_s1;
	logic                 out_last_s1;
	logic                 out_vld_s1;
	logic                 result_valid_q;
	logic [IDX_W-1:0]     out_row_q;
	logic signed [DATA_WIDTH-1:0] out_value_q;
	logic                 out_last_q;

	// decoded control
	int                   rows_eff, cols_eff;
	logic [ROW_W-1:0]     rows_last;
	logic                 item_xfer;
	logic                 is_last_row;
	logic                 mac_issue, out_issue;
	logic                 col_in_use;

	// RAM ports
	logic                 w_we;
	logic [WADDR_W-1:0]   w_waddr;
	logic [DATA_WIDTH-1:0] w_rdata;
	logic                 b_we;
	logic [DATA_WIDTH-1:0] b_rdata;
	logic                 acc_we;
	logic [ACC_W-1:0]     acc_wdata;
	logic [ACC_W-1:0]     acc_rdata;

	// arithmetic
	logic signed [MSUM_W-1:0] msum;
	logic signed [ACC_W-1:0]  acc_out_val;
	logic signed [SUM_W-1:0]  osum;
	logic signed [Q_W-1:0]    oq;
	logic signed [DATA_WIDTH-1:0] oval;

	// effective counts
	assign rows_eff    = clamp_count(output_count_q, MAX_OUTPUTS);
	assign cols_eff    = clamp_count(input_count_q, MAX_INPUTS);
	assign rows_last   = ROW_W'(rows_eff - 1);
	assign is_last_row = (row_q == rows_last);
	assign col_in_use  = (int'(col_index) < cols_eff);

	assign item_ready = (state_q == ST_IDLE);
	assign item_xfer  = item_valid && item_ready;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			input_count_q  <= CNT_RESET;
			output_count_q <= CNT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_INPUT_COUNT:  input_count_q  <= cfg_data;
				REG_OUTPUT_COUNT: output_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// next state and issue strobes
	always_comb begin
		state_d   = state_q;
		mac_issue = 1'b0;
		out_issue = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (item_xfer && (op == OP_ELEM)) begin
					if (col_in_use)
						state_d = ST_MAC;
					else if (vector_end)
						state_d = ST_OUT;
				end
			end
			ST_MAC: begin
				mac_issue = 1'b1;
				if (is_last_row)
					state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!mac_s1_v && !mac_s2_v)
					state_d = last_q ? ST_OUT : ST_IDLE;
			end
			ST_OUT: begin
				out_issue = !out_s1_v && (!result_valid_q || result_ready);
				if (out_issue && is_last_row)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// row walk, element latch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
		end else if (item_xfer) begin
			row_q <= '0;
		end else if (mac_issue || out_issue) begin
			row_q <= is_last_row ? '0 : row_q + ROW_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (item_xfer) begin
			val_q   <= value;
			last_q  <= vector_end;
			waddr_q <= WADDR_W'(col_index);
		end else if (mac_issue) begin
			waddr_q <= waddr_q + WADDR_W'(MAX_INPUTS);
		end
	end

	// accumulator valid bits: clear as a vector closes, set on write-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_valid_q <= '0;
		end else if (out_issue && is_last_row) begin
			acc_valid_q <= '0;
		end else if (mac_s2_v) begin
			acc_valid_q[mac_row_s2] <= 1'b1;
		end
	end

	// store writes from load items
	assign w_we = item_xfer && (op == OP_WEIGHT) && (int'(row_index) < MAX_OUTPUTS)
		&& (int'(col_index) < MAX_INPUTS);
	assign w_waddr = WADDR_W'(int'(row_index) * MAX_INPUTS + int'(col_index));
	assign b_we = item_xfer && (op == OP_BIAS) && (int'(row_index) < MAX_OUTPUTS);

	fcl_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (MAX_OUTPUTS * MAX_INPUTS)
	) u_weight_ram (
		.clk   (clk),
		.we    (w_we),
		.waddr (w_waddr),
		.wdata (value),
		.re    (mac_issue),
		.raddr (waddr_q),
		.rdata (w_rdata)
	);

	fcl_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (MAX_OUTPUTS)
	) u_bias_ram (
		.clk   (clk),
		.we    (b_we),
		.waddr (ROW_W'(row_index)),
		.wdata (value),
		.re    (out_issue),
		.raddr (row_q),
		.rdata (b_rdata)
	);

	fcl_ram #(
		.WIDTH (ACC_W),
		.DEPTH (MAX_OUTPUTS)
	) u_acc_ram (
		.clk   (clk),
		.we    (acc_we),
		.waddr (mac_row_s2),
		.wdata (acc_wdata),
		.re    (mac_issue || out_issue),
		.raddr (row_q),
		.rdata (acc_rdata)
	);

	// MAC pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mac_s1_v <= 1'b0;
			mac_s2_v <= 1'b0;
		end else begin
			mac_s1_v <= mac_issue;
			mac_s2_v <= mac_s1_v;
		end
	end

	// stage 1 -> 2: multiply, unwritten accumulator rows read as zero
	always_ff @(posedge clk) begin
		if (mac_issue) begin
			mac_row_s1 <= row_q;
			mac_vld_s1 <= acc_valid_q[row_q];
		end
		if (mac_s1_v) begin
			mac_row_s2 <= mac_row_s1;
			prod_s2    <= $signed(w_rdata) * val_q;
			acc_s2     <= mac_vld_s1 ? $signed(acc_rdata) : '0;
		end
	end

	// stage 2: accumulate, saturate to the accumulator range, write back
	assign msum = MSUM_W'(acc_s2) + MSUM_W'(prod_s2);
	always_comb begin
		if ((&msum[MSUM_W-1:ACC_W-1]) || !(|msum[MSUM_W-1:ACC_W-1]))
			acc_wdata = msum[ACC_W-1:0];
		else if (msum[MSUM_W-1])
			acc_wdata = ACC_MIN;
		else
			acc_wdata = ACC_MAX;
	end
	assign acc_we = mac_s2_v;

	// output pass: one row in flight, output slot reserved at issue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_s1_v <= 1'b0;
		end else begin
			out_s1_v <= out_issue;
		end
	end

	always_ff @(posedge clk) begin
		if (out_issue) begin
			out_row_s1  <= row_q;
			out_last_s1 <= is_last_row;
			out_vld_s1  <= acc_valid_q[row_q];
		end
	end

	// add bias, round half up to Q8.8, saturate
	assign acc_out_val = out_vld_s1 ? $signed(acc_rdata) : '0;
	assign osum = SUM_W'(acc_out_val) + (SUM_W'($signed(b_rdata)) <<< FRAC_W) + ROUND_HALF;
	assign oq   = osum[SUM_W-1:FRAC_W];
	always_comb begin
		if ((&oq[Q_W-1:DATA_WIDTH-1]) || !(|oq[Q_W-1:DATA_WIDTH-1]))
			oval = oq[DATA_WIDTH-1:0];
		else if (oq[Q_W-1])
			oval = DATA_MIN;
		else
			oval = DATA_MAX;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_s1_v) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_s1_v) begin
			out_row_q   <= IDX_W'(out_row_s1);
			out_value_q <= oval;
			out_last_q  <= out_last_s1;
		end
	end

	assign result_valid = result_valid_q;
	assign out_row      = out_row_q;
	assign out_value    = out_value_q;
	assign out_last     = out_last_q;

	// checks
	`FCL_ASSERT(a_out_slot_free, out_s1_v |-> (!result_valid_q || result_ready), "output register overwritten before transfer")
	`FCL_ASSERT(a_ready_drained, item_ready |-> (!mac_s1_v && !mac_s2_v), "item taken while accumulator write-back pending")
	`FCL_ASSERT_NEVER(a_acc_port_clash, out_s1_v && mac_s2_v, "output read overlaps accumulator write-back")
	`FCL_ASSERT(a_result_held, (result_valid_q && !result_ready) |=> (result_valid_q && $stable(out_value_q)), "result dropped or changed before transfer")

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the dense layer forward block (out = W*x + b).
// A directed run covers the field extremes, rounding of halves, saturation,
// ignored ops and fields, unused and repeated columns, and a vector left open
// across a register write. Random vectors with shuffled columns and random
// noise items follow under several layer sizes, including zero and
// oversized counts. Sender bursts and receiver stalls are random. Every
// accepted item is run through a bit-exact predictor, and each result
// transfer is checked field by field against the oldest expected row.
// ----------------------------------------------------------------------------
module testbench;
	import fcl_pkg::*;

	localparam int DW   = DATA_WIDTH_DEF;
	localparam int ROWS = MAX_OUTPUTS_DEF;
	localparam int COLS = MAX_INPUTS_DEF;

	localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

	localparam longint ACC_HI = 64'sh0000_007F_FFFF_FFFF;
	localparam longint ACC_LO = -ACC_HI - 1;
	localparam longint OUT_HI = 32767;
	localparam longint OUT_LO = -32768;

	localparam int SETTLE_CYCLES = 64;
	localparam int CYCLE_LIMIT   = 500000;
	localparam int RANDOM_ITEMS  = 176;
	localparam int PHASES        = 8;
	localparam int MAX_REPORTS   = 40;

	typedef struct {
		logic [OP_W-1:0]  op;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic [DW-1:0]    value;
		logic             vend;
	} item_t;

	typedef struct {
		logic [IDX_W-1:0] row;
		logic [DW-1:0]    value;
		logic             last;
	} row_result_t;

	// DUT signals; the driven inputs are known from time zero
	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [REG_IDX_W-1:0] cfg_index = '0;
	logic [CNT_W-1:0]     cfg_data = '0;
	logic                 item_valid = 1'b0;
	logic                 item_ready;
	logic [OP_W-1:0]      op = '0;
	logic [IDX_W-1:0]     row_index = '0;
	logic [IDX_W-1:0]     col_index = '0;
	logic [DW-1:0]        value = '0;
	logic                 vector_end = 1'b0;
	logic                 result_valid;
	logic                 result_ready = 1'b0;
	logic [IDX_W-1:0]     out_row;
	logic [DW-1:0]        out_value;
	logic                 out_last;

	// predictor state
	logic signed [DW-1:0] weight_mem [ROWS][COLS];
	logic signed [DW-1:0] bias_mem [ROWS];
	logic signed [39:0]   row_acc [ROWS] = '{default: '0};
	logic [CNT_W-1:0]     cols_reg = CNT_RESET;
	logic [CNT_W-1:0]     rows_reg = CNT_RESET;

	// stimulus side: what has been loaded so far and the sizes in use
	bit weight_loaded [ROWS][COLS] = '{default: 1'b0};
	bit bias_loaded [ROWS] = '{default: 1'b0};
	int gen_cols = COLS;
	int gen_rows = ROWS;
	int items_queued = 0;

	item_t       pending_items [$];
	row_result_t expected_rows [$];
	item_t       next_item;

	bit  item_taken = 1'b0;
	int  burst_left = 1;
	int  gap_left = 0;
	int  stall_mode = 0;
	int  mode_left = 0;
	int  mismatches = 0;
	int  cycle_count = 0;

	fully_connected_layer_forward_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.op           (op),
		.row_index    (row_index),
		.col_index    (col_index),
		.value        (value),
		.vector_end   (vector_end),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.out_row      (out_row),
		.out_value    (out_value),
		.out_last     (out_last)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// count of zero means one, oversized counts mean the maximum
	function automatic int in_use(input logic [CNT_W-1:0] c, input int maxv);
		if (c == 0)
			return 1;
		if (int'(c) > maxv)
			return maxv;
		return int'(c);
	endfunction

	// one accepted item through the layer; closing a vector queues its rows
	task automatic forward_item(input logic [OP_W-1:0] o, input logic [IDX_W-1:0] r,
			input logic [IDX_W-1:0] c, input logic signed [DW-1:0] v, input logic vend);
		int          n_rows;
		int          n_cols;
		int          k;
		longint      sum;
		row_result_t res;
		n_rows = in_use(rows_reg, ROWS);
		n_cols = in_use(cols_reg, COLS);
		case (o)
			OP_WEIGHT: weight_mem[r][c] = v;
			OP_BIAS:   bias_mem[r] = v;
			OP_ELEM: begin
				if (int'(c) < n_cols) begin
					for (k = 0; k < n_rows; k++) begin
						sum = longint'(row_acc[k]) + longint'(weight_mem[k][c]) * longint'(v);
						if (sum > ACC_HI)
							sum = ACC_HI;
						if (sum < ACC_LO)
							sum = ACC_LO;
						row_acc[k] = sum[39:0];
					end
				end
				if (vend) begin
					for (k = 0; k < n_rows; k++) begin
						// round half up to Q8.8, then saturate
						sum = longint'(row_acc[k]) + longint'(bias_mem[k]) * 256 + 128;
						sum = sum >>> 8;
						if (sum > OUT_HI)
							sum = OUT_HI;
						if (sum < OUT_LO)
							sum = OUT_LO;
						res.row   = k[IDX_W-1:0];
						res.value = sum[DW-1:0];
						res.last  = (k == n_rows - 1);
						expected_rows.insert(expected_rows.size(), res);
					end
					for (k = 0; k < ROWS; k++)
						row_acc[k] = '0;
				end
			end
			default: ;
		endcase
	endtask

	task automatic report_mismatch(input string what, input longint want, input longint got);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
	endtask

	task automatic check_row_result();
		row_result_t want;
		if (expected_rows.size() == 0) begin
			report_mismatch("result with none pending, out_row", -1, out_row);
			return;
		end
		want = expected_rows.pop_front();
		if (out_row !== want.row)
			report_mismatch("out_row", want.row, out_row);
		if (out_value !== want.value)
			report_mismatch("out_value", longint'($signed(want.value)),
				longint'($signed(out_value)));
		if (out_last !== want.last)
			report_mismatch("out_last", want.last, out_last);
	endtask

	// stimulus helpers
	function automatic logic [DW-1:0] pick_value();
		case ($urandom_range(0, 7))
			0:       return 16'h7FFF;
			1:       return 16'h8000;
			2, 3, 4: return DW'($urandom_range(0, 1023)) - DW'(512);
			default: return DW'($urandom);
		endcase
	endfunction

	task automatic push_item(input logic [OP_W-1:0] o, input int r, input int c,
			input logic [DW-1:0] v, input logic vend);
		item_t it;
		it.op    = o;
		it.row   = r[IDX_W-1:0];
		it.col   = c[IDX_W-1:0];
		it.value = v;
		it.vend  = vend;
		if (o == OP_WEIGHT)
			weight_loaded[r][c] = 1'b1;
		if (o == OP_BIAS)
			bias_loaded[r] = 1'b1;
		pending_items.insert(pending_items.size(), it);
		items_queued++;
	endtask

	// no weight or bias is ever read before it was loaded
	task automatic need_weights(input int c);
		int r;
		if (c < gen_cols)
			for (r = 0; r < gen_rows; r++)
				if (!weight_loaded[r][c])
					push_item(OP_WEIGHT, r, c, pick_value(), 1'($urandom));
	endtask

	task automatic need_biases();
		int r;
		for (r = 0; r < gen_rows; r++)
			if (!bias_loaded[r])
				push_item(OP_BIAS, r, 0, pick_value(), 1'($urandom));
	endtask

	// every queued item counts towards the phase budget
	task automatic gen_phase(input int target);
		int start;
		int n;
		int i;
		int j;
		int tmp;
		int c;
		int order [COLS];
		start = items_queued;
		while (items_queued - start < target) begin
			if ($urandom_range(0, 9) < 7) begin
				// well-formed vector, columns shuffled, sometimes after a few reloads
				if ($urandom_range(0, 3) == 0) begin
					n = $urandom_range(1, 4);
					for (i = 0; i < n; i++)
						push_item(OP_WEIGHT, $urandom_range(0, gen_rows - 1),
							$urandom_range(0, gen_cols - 1), pick_value(), 1'($urandom));
					push_item(OP_BIAS, $urandom_range(0, gen_rows - 1), $urandom_range(0, COLS - 1),
						pick_value(), 1'($urandom));
				end
				for (i = 0; i < gen_cols; i++)
					order[i] = i;
				for (i = gen_cols - 1; i > 0; i--) begin
					j = $urandom_range(0, i);
					tmp = order[i];
					order[i] = order[j];
					order[j] = tmp;
				end
				for (i = 0; i < gen_cols; i++) begin
					need_weights(order[i]);
					if (i == gen_cols - 1)
						need_biases();
					push_item(OP_ELEM, $urandom_range(0, ROWS - 1), order[i], pick_value(),
						i == gen_cols - 1);
				end
			end else begin
				// noise: reserved ops, stray loads, lone or out-of-use elements
				case ($urandom_range(0, 3))
					0: push_item(OP_RESERVED, $urandom_range(0, ROWS - 1),
						$urandom_range(0, COLS - 1), DW'($urandom), 1'($urandom));
					1: push_item(OP_WEIGHT, $urandom_range(0, ROWS - 1),
						$urandom_range(0, COLS - 1), pick_value(), 1'($urandom));
					2: push_item(OP_BIAS, $urandom_range(0, ROWS - 1),
						$urandom_range(0, COLS - 1), pick_value(), 1'($urandom));
					default: begin
						c = $urandom_range(0, COLS - 1);
						tmp = int'($urandom_range(0, 2) == 0);
						need_weights(c);
						if (tmp != 0)
							need_biases();
						push_item(OP_ELEM, $urandom_range(0, ROWS - 1), c, pick_value(), tmp != 0);
					end
				endcase
			end
		end
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input int data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data[CNT_W-1:0];
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic set_layer(input int n_in, input int n_out);
		write_reg(REG_INPUT_COUNT, n_in);
		write_reg(REG_OUTPUT_COUNT, n_out);
		gen_cols = in_use(n_in[CNT_W-1:0], COLS);
		gen_rows = in_use(n_out[CNT_W-1:0], ROWS);
	endtask

	// all items taken, all rows back, then let the pipeline settle
	task automatic wait_idle();
		while (pending_items.size() != 0 || item_valid || expected_rows.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// sender: take note of transfers and feed the predictor
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
					REG_INPUT_COUNT:  cols_reg = cfg_data;
					REG_OUTPUT_COUNT: rows_reg = cfg_data;
					default: ;
				endcase
			end
			if (item_valid && item_ready) begin
				forward_item(op, row_index, col_index, value, vector_end);
				item_taken = 1'b1;
			end
		end
	end

	// sender: present the next item, in bursts with gaps between
	always @(negedge clk) begin
		if (arst_n) begin
			if (!item_valid || item_taken) begin
				if (gap_left > 0) begin
					item_valid <= 1'b0;
					gap_left--;
				end else if (pending_items.size() != 0) begin
					next_item = pending_items.pop_front();
					item_valid <= 1'b1;
					op         <= next_item.op;
					row_index  <= next_item.row;
					col_index  <= next_item.col;
					value      <= next_item.value;
					vector_end <= next_item.vend;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
					end
				end else begin
					item_valid <= 1'b0;
				end
			end
			item_taken = 1'b0;
		end
	end

	// receiver: ready pattern switches between free, random, starved and periodic
	always @(negedge clk) begin
		if (arst_n) begin
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				mode_left = $urandom_range(8, 60);
			end
			mode_left--;
			case (stall_mode)
				0:       result_ready <= 1'b1;
				1:       result_ready <= 1'($urandom);
				2:       result_ready <= ($urandom_range(0, 7) == 0);
				default: result_ready <= (mode_left % 3 != 0);
			endcase
		end
	end

	// monitor and watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else if (arst_n && result_valid && result_ready) begin
			check_row_result();
		end
	end

	initial begin
		int p;
		int ph_in [PHASES];
		int ph_out [PHASES];
		// sizes kept small enough that weight loading stays a modest share
		ph_in  = '{1, 0, 16, 5, 31, 2, 0, 0};
		ph_out = '{1, 0, 2, 3, 1, 31, 0, 0};
		ph_in[6]  = $urandom_range(0, 31);
		ph_out[6] = $urandom_range(0, 3);
		ph_in[7]  = $urandom_range(1, 4);
		ph_out[7] = $urandom_range(1, 16);

		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		// directed run on a 2 x 2 layer
		set_layer(2, 2);
		push_item(OP_WEIGHT, 0, 0, 16'h7FFF, 1'b0);
		push_item(OP_WEIGHT, 0, 1, 16'h8000, 1'b0);
		push_item(OP_WEIGHT, 1, 0, 16'h0001, 1'b0);
		push_item(OP_WEIGHT, 1, 1, 16'hFFFF, 1'b0);
		// vector end on a load is ignored
		push_item(OP_BIAS, 0, 15, 16'h7FFF, 1'b1);
		push_item(OP_BIAS, 1, 0, 16'h8000, 1'b0);
		push_item(OP_RESERVED, 15, 15, 16'hFFFF, 1'b1);
		// extremes: row 0 saturates high; row index on elements is ignored
		push_item(OP_ELEM, 15, 0, 16'h7FFF, 1'b0);
		push_item(OP_ELEM, 0, 1, 16'h8000, 1'b1);
		// repeated column accumulates twice
		push_item(OP_ELEM, 0, 1, 16'h0100, 1'b0);
		push_item(OP_ELEM, 0, 1, 16'h0100, 1'b0);
		push_item(OP_ELEM, 0, 0, 16'h0200, 1'b1);
		// column not in use still closes the vector: bias only
		push_item(OP_ELEM, 0, 15, 16'h7FFF, 1'b1);
		// halves round upward, both signs
		push_item(OP_WEIGHT, 0, 0, 16'h0001, 1'b0);
		push_item(OP_WEIGHT, 1, 0, 16'hFFFF, 1'b0);
		push_item(OP_BIAS, 0, 0, 16'h0000, 1'b0);
		push_item(OP_BIAS, 1, 0, 16'h0000, 1'b0);
		push_item(OP_ELEM, 0, 0, 16'h0080, 1'b1);
		push_item(OP_ELEM, 0, 0, 16'hFF80, 1'b1);
		// saturation low
		push_item(OP_WEIGHT, 0, 0, 16'h8000, 1'b0);
		push_item(OP_BIAS, 0, 0, 16'h8000, 1'b0);
		push_item(OP_ELEM, 0, 0, 16'h7FFF, 1'b1);
		// open vector carried across the next register write
		push_item(OP_ELEM, 0, 3, 16'h7FFF, 1'b0);
		push_item(OP_ELEM, 0, 0, 16'h0100, 1'b0);
		wait_idle();

		// random phases over a range of layer sizes
		for (p = 0; p < PHASES; p++) begin
			set_layer(ph_in[p], ph_out[p]);
			gen_phase(RANDOM_ITEMS / PHASES);
			wait_idle();
		end

		if (mismatches == 0 && expected_rows.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

>>> files.f
+incdir+hdl
hdl/fcl_pkg.sv
hdl/fcl_ram.sv
hdl/fully_connected_layer_forward_top.sv
test/testbench.sv
